// File: hw/rtl/pft_pkg.sv
// Shared types, sizes and the item carried along the page frame table cell chain.
package pft_pkg;

    localparam int FRAME_COUNT = 128;
    localparam int OWNER_BITS  = 8;
    localparam int PAGE_BITS   = 10;

    localparam int IDX_W = $clog2(FRAME_COUNT);
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    localparam int OPCODE_W   = 2;
    localparam int PROC_W     = 8;
    localparam int PAGE_IN_W  = 10;
    localparam int NEED_W     = 8;
    localparam int FRAME_IO_W = 7;
    localparam int FREE_IO_W  = 8;

    typedef logic [OWNER_BITS-1:0] owner_t;
    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [NEED_W-1:0]     need_t;
    typedef logic [FRAME_IO_W-1:0] frame_io_t;
    typedef logic [FREE_IO_W-1:0]  free_io_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOOKUP  = 2'd0,
        OP_CHECK   = 2'd1,
        OP_ALLOC   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef struct packed {
        logic   valid;
        op_t    op;
        owner_t pid;
        page_t  page;
        need_t  need;
        logic   hit;
        idx_t   frame;
        cnt_t   count;
    } item_t;

endpackage

// File: hw/rtl/pft_cell.sv
// One frame of the table: holds its tag and updates the item passing through it.
module pft_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  pft_pkg::idx_t  frame_id,
    input  pft_pkg::item_t bus_in,
    output pft_pkg::item_t bus_out
);
    import pft_pkg::*;

    logic   in_use_reg;
    logic   in_use_next;
    owner_t owner_reg;
    page_t  page_reg;
    logic   claim;
    logic   owner_match;
    item_t  bus_reg;
    item_t  bus_next;

    assign owner_match = in_use_reg && (owner_reg == bus_in.pid);
    assign claim = (bus_in.op == OP_ALLOC) && !bus_in.hit && !in_use_reg;

    always_comb begin
        bus_next    = bus_in;
        in_use_next = in_use_reg;
        case (bus_in.op)
            OP_LOOKUP: begin
                if (!bus_in.hit && owner_match && (page_reg == bus_in.page)) begin
                    bus_next.hit   = 1'b1;
                    bus_next.frame = frame_id;
                end
            end
            OP_CHECK: begin
            end
            OP_ALLOC: begin
                if (claim) begin
                    in_use_next    = 1'b1;
                    bus_next.hit   = 1'b1;
                    bus_next.frame = frame_id;
                end
            end
            OP_RELEASE: begin
                if (owner_match) begin
                    in_use_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
        bus_next.count = bus_in.count + cnt_t'(!in_use_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg    <= 1'b0;
            bus_reg.valid <= 1'b0;
        end else if (advance) begin
            bus_reg <= bus_next;
            if (bus_in.valid) begin
                in_use_reg <= in_use_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && bus_in.valid && claim) begin
            owner_reg <= bus_in.pid;
            page_reg  <= bus_in.page;
        end
    end

    assign bus_out = bus_reg;

endmodule

// File: hw/rtl/pft_resp.sv
// Result register at the end of the chain: forms the result item and holds it for the sink.
module pft_resp (
    input  logic                aclk,
    input  logic                aresetn,
    input  pft_pkg::item_t      bus_in,
    input  logic                m_ready,
    output logic                advance,
    output logic                m_valid,
    output logic                m_success,
    output pft_pkg::frame_io_t  m_frame_index,
    output pft_pkg::free_io_t   m_free_frames
);
    import pft_pkg::*;

    logic      valid_reg;
    logic      success_reg;
    logic      success_next;
    frame_io_t frame_reg;
    frame_io_t frame_next;
    free_io_t  free_reg;

    assign advance = !valid_reg || m_ready;

    always_comb begin
        case (bus_in.op)
            OP_CHECK:   success_next = (cmp_t'(bus_in.count) >= cmp_t'(bus_in.need));
            OP_RELEASE: success_next = 1'b1;
            default:    success_next = bus_in.hit;
        endcase
        frame_next = bus_in.hit ? frame_io_t'(bus_in.frame) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= bus_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            success_reg <= success_next;
            frame_reg   <= frame_next;
            free_reg    <= free_io_t'(bus_in.count);
        end
    end

    assign m_valid       = valid_reg;
    assign m_success     = success_reg;
    assign m_frame_index = frame_reg;
    assign m_free_frames = free_reg;

endmodule

// File: hw/rtl/page_frame_table.sv
// Page frame table top level: chain of frame cells followed by the result register.
//
//  channel   direction  handshake          fields
//  s_        in         s_valid/s_ready    opcode, process_id, page_number, free_needed
//  m_        out        m_valid/m_ready    success, frame_index, free_frames
//
//  An item walks the chain one frame cell per cycle while the chain advances,
//  passing every frame cell register and then the result register. The chain
//  is a pipeline, so with m_ready held high one item is taken every cycle.
//  Reset clears every in-use bit at once; owner and page tags are not reset.
//  When the result register is full and m_ready is low, the whole chain holds.
module page_frame_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [7:0]          s_process_id,
    input  logic [9:0]          s_page_number,
    input  logic [7:0]          s_free_needed,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_success,
    output logic [6:0]          m_frame_index,
    output logic [7:0]          m_free_frames
);
    import pft_pkg::*;

    item_t chain [FRAME_COUNT+1];
    logic  advance;

    always_comb begin
        chain[0].valid = s_valid;
        chain[0].op    = op_t'(s_opcode);
        chain[0].pid   = owner_t'(s_process_id);
        chain[0].page  = page_t'(s_page_number);
        chain[0].need  = s_free_needed;
        chain[0].hit   = 1'b0;
        chain[0].frame = '0;
        chain[0].count = '0;
    end

    for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
        pft_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .frame_id (idx_t'(i)),
            .bus_in   (chain[i]),
            .bus_out  (chain[i+1])
        );
    end

    pft_resp u_resp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bus_in        (chain[FRAME_COUNT]),
        .m_ready       (m_ready),
        .advance       (advance),
        .m_valid       (m_valid),
        .m_success     (m_success),
        .m_frame_index (m_frame_index),
        .m_free_frames (m_free_frames)
    );

    assign s_ready = advance;

`ifndef SYNTHESIS
    a_no_frame_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_success) |-> (m_frame_index == '0))
        else $error("failed result carries a frame index");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[FRAME_COUNT].valid |-> (chain[FRAME_COUNT].count <= cnt_t'(FRAME_COUNT)))
        else $error("free count exceeds frame count");

    a_check_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain[FRAME_COUNT].valid && (chain[FRAME_COUNT].op == OP_CHECK
            || chain[FRAME_COUNT].op == OP_RELEASE)) |-> !chain[FRAME_COUNT].hit)
        else $error("check or release item picked up a frame hit");

    a_chain_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(chain[FRAME_COUNT]))
        else $error("chain advanced while result register was full");
`endif

endmodule

// File: verif/page_frame_table_tb.sv
// Self-checking testbench for the page frame table: predicts every result and compares it.
`timescale 1ns / 1ps

module page_frame_table_tb;

    import pft_pkg::*;

    localparam int POOL_SIZE      = 8;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTS     = 40;

    typedef struct {
        logic      success;
        frame_io_t frame;
        free_io_t  free_cnt;
    } frame_result_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_opcode      = '0;
    logic [7:0] s_process_id  = '0;
    logic [9:0] s_page_number = '0;
    logic [7:0] s_free_needed = '0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_success;
    logic [6:0] m_frame_index;
    logic [7:0] m_free_frames;

    logic       tbl_used  [FRAME_COUNT];
    owner_t     tbl_owner [FRAME_COUNT];
    page_t      tbl_page  [FRAME_COUNT];

    frame_result_t expected_results[$];
    logic [7:0]    pid_pool[POOL_SIZE];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int stall_cycles   = 0;

    page_frame_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_process_id  (s_process_id),
        .s_page_number (s_page_number),
        .s_free_needed (s_free_needed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_success     (m_success),
        .m_frame_index (m_frame_index),
        .m_free_frames (m_free_frames)
    );

    always #4 aclk = ~aclk;

    function automatic int free_count();
        int n;
        n = 0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (!tbl_used[i]) n++;
        end
        return n;
    endfunction

    function automatic int resident_frame();
        int slots[$];
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (tbl_used[i]) slots.push_back(i);
        end
        if (slots.size() == 0) return -1;
        return slots[$urandom_range(0, slots.size() - 1)];
    endfunction

    function automatic frame_result_t predict_frame_op(op_t op, owner_t pid, page_t pg,
                                                       need_t need);
        frame_result_t res;
        res.success = 1'b0;
        res.frame   = '0;
        case (op)
            OP_LOOKUP: begin
                for (int i = 0; i < FRAME_COUNT; i++) begin
                    if (!res.success && tbl_used[i] && tbl_owner[i] == pid
                            && tbl_page[i] == pg) begin
                        res.success = 1'b1;
                        res.frame   = frame_io_t'(i);
                    end
                end
            end
            OP_CHECK: begin
                res.success = (free_count() >= int'(need));
            end
            OP_ALLOC: begin
                for (int i = 0; i < FRAME_COUNT; i++) begin
                    if (!res.success && !tbl_used[i]) begin
                        tbl_used[i]  = 1'b1;
                        tbl_owner[i] = pid;
                        tbl_page[i]  = pg;
                        res.success  = 1'b1;
                        res.frame    = frame_io_t'(i);
                    end
                end
            end
            default: begin
                for (int i = 0; i < FRAME_COUNT; i++) begin
                    if (tbl_used[i] && tbl_owner[i] == pid) tbl_used[i] = 1'b0;
                end
                res.success = 1'b1;
            end
        endcase
        res.free_cnt = free_io_t'(free_count());
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int idx, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("MISMATCH result %0d %s: got %0d expected %0d", idx, field, got, want);
        end
    endtask

    // Result checking and prediction, in acceptance order.
    always @(posedge aclk) begin : item_monitor
        frame_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", results_seen, 32'(m_success), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_success !== want.success)
                        report_mismatch("success", results_seen, 32'(m_success),
                                        32'(want.success));
                    if (m_frame_index !== want.frame)
                        report_mismatch("frame_index", results_seen, 32'(m_frame_index),
                                        32'(want.frame));
                    if (m_free_frames !== want.free_cnt)
                        report_mismatch("free_frames", results_seen, 32'(m_free_frames),
                                        32'(want.free_cnt));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_frame_op(op_t'(s_opcode),
                    owner_t'(s_process_id), page_t'(s_page_number), need_t'(s_free_needed)));
            end
        end
    end

    always @(posedge aclk) begin : sink_drive
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("page_frame_table_tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(input op_t op, input logic [7:0] pid, input logic [9:0] pg,
                             input logic [7:0] need);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_process_id  <= pid;
        s_page_number <= pg;
        s_free_needed <= need;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_item();
        int         r;
        int         slot;
        op_t        op;
        logic [7:0] pid;
        logic [9:0] pg;
        logic [7:0] need;
        r    = $urandom_range(0, 99);
        pid  = pid_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 9) == 0) pid = 8'($urandom);
        pg   = 10'($urandom);
        need = 8'($urandom);
        if (r < 40) begin
            op = OP_ALLOC;
        end else if (r < 72) begin
            op   = OP_LOOKUP;
            slot = resident_frame();
            if (slot >= 0 && $urandom_range(0, 9) < 7) begin
                pid = tbl_owner[slot];
                pg  = tbl_page[slot];
                // near miss on one page bit
                if ($urandom_range(0, 9) == 0) pg = pg ^ (10'd1 << $urandom_range(0, 9));
            end
        end else if (r < 88) begin
            op = OP_CHECK;
            if ($urandom_range(0, 1) == 1) need = 8'(free_count() + $urandom_range(0, 2) - 1);
        end else begin
            op   = OP_RELEASE;
            slot = resident_frame();
            if (slot >= 0 && $urandom_range(0, 9) < 8) pid = tbl_owner[slot];
        end
        send_item(op, pid, pg, need);
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(OP_CHECK,   8'h00, 10'h000, 8'd0);
        send_item(OP_CHECK,   8'h00, 10'h000, 8'd128);
        send_item(OP_CHECK,   8'h00, 10'h000, 8'd129);
        send_item(OP_CHECK,   8'hFF, 10'h3FF, 8'd255);
        send_item(OP_LOOKUP,  8'h00, 10'h000, 8'd0);
        send_item(OP_RELEASE, 8'h5A, 10'h2AA, 8'd0);
        send_item(OP_ALLOC,   8'hFF, 10'h3FF, 8'd0);
        send_item(OP_ALLOC,   8'h00, 10'h000, 8'd0);
        send_item(OP_ALLOC,   8'h00, 10'h000, 8'd0);
        send_item(OP_ALLOC,   8'hA5, 10'h155, 8'd0);
        send_item(OP_LOOKUP,  8'hFF, 10'h3FF, 8'd0);
        send_item(OP_LOOKUP,  8'h00, 10'h000, 8'd0);
        send_item(OP_LOOKUP,  8'h00, 10'h3FF, 8'd0);
        send_item(OP_LOOKUP,  8'hFF, 10'h000, 8'd0);
        send_item(OP_LOOKUP,  8'h5A, 10'h2AA, 8'd0);
        send_item(OP_CHECK,   8'h00, 10'h000, 8'd124);
        send_item(OP_CHECK,   8'h00, 10'h000, 8'd125);
        send_item(OP_RELEASE, 8'h00, 10'h000, 8'd0);
        send_item(OP_LOOKUP,  8'h00, 10'h000, 8'd0);
        send_item(OP_ALLOC,   8'h3C, 10'h0F0, 8'd0);
        send_item(OP_RELEASE, 8'hFF, 10'h000, 8'd0);
        send_item(OP_RELEASE, 8'hA5, 10'h000, 8'd0);
        send_item(OP_RELEASE, 8'h3C, 10'h000, 8'd0);
        send_item(OP_CHECK,   8'h00, 10'h000, 8'd0);
        wait_drained();
    endtask

    task automatic test_fill_and_drain();
        int slot;
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        repeat (FRAME_COUNT + 3) begin
            send_item(OP_ALLOC, pid_pool[$urandom_range(0, POOL_SIZE - 1)], 10'($urandom),
                      8'($urandom));
        end
        send_item(OP_CHECK, 8'h00, 10'h000, 8'd0);
        send_item(OP_CHECK, 8'h00, 10'h000, 8'd1);
        repeat (4) begin
            slot = resident_frame();
            if (slot >= 0) send_item(OP_LOOKUP, tbl_owner[slot], tbl_page[slot], 8'd0);
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            send_item(OP_RELEASE, pid_pool[i], 10'($urandom), 8'($urandom));
        end
        send_item(OP_CHECK, 8'h00, 10'h000, 8'd128);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n_items) send_random_item();
        wait_drained();
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req++;
        repeat (200) send_random_item();
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < FRAME_COUNT; i++) tbl_used[i] = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) pid_pool[i] = 8'($urandom);
        pid_pool[0]             = 8'h00;
        pid_pool[POOL_SIZE - 1] = 8'hFF;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fill_and_drain();
        test_random_traffic(170, 0, 0);
        test_random_traffic(170, 79, 0);
        test_random_traffic(170, 0, 79);
        test_random_traffic(170, 20, 20);
        test_backpressure();
        repeat (FRAME_COUNT + 16) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("page_frame_table_tb OK");
        end else begin
            $display("page_frame_table_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/pft_pkg.sv
hw/rtl/pft_cell.sv
hw/rtl/pft_resp.sv
hw/rtl/page_frame_table.sv
verif/page_frame_table_tb.sv
